[rtl/aod_pkg.sv]
// shared types and constants of the obu stream deframer
package aod_pkg;

    // one stream byte as it travels from the front end to the parser
    typedef struct packed {
        logic       eos;
        logic [7:0] data;
    } byte_item_t;

    // queue status seen by its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FORBIDDEN = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    localparam int HDR_FORBIDDEN_BIT = 7;
    localparam int HDR_EXT_BIT       = 2;
    localparam int HDR_SIZE_BIT      = 1;
    localparam int LEB_CONT_BIT      = 7;

    localparam logic [3:0] LEB_LAST_INDEX = 4'd8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

endpackage

[rtl/aod_front.sv]
// front end: accepts stream bytes and tags each with its stream offset
module aod_front #(
    parameter int OFFSET_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  aod_pkg::byte_item_t     in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output aod_pkg::byte_item_t     out_item,
    output logic [OFFSET_BITS-1:0]  out_offset
);
    import aod_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    byte_item_t             item_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] stream_off_reg;
    logic [OFFSET_BITS-1:0] stream_off_next;
    logic                   take;

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign out_valid  = valid_reg;
    assign out_item   = item_reg;
    assign out_offset = offset_reg;

    always_comb
    begin
        valid_next      = valid_reg;
        stream_off_next = stream_off_reg;
        if (take)
        begin
            valid_next = 1'b1;
            // end of stream restarts the offset count
            if (in_item.eos)
                stream_off_next = '0;
            else
                stream_off_next = stream_off_reg + OFFSET_BITS'(1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            stream_off_reg <= '0;
        end
        else
        begin
            valid_reg      <= valid_next;
            stream_off_reg <= stream_off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg   <= in_item;
            offset_reg <= stream_off_reg;
        end
    end

endmodule

[rtl/aod_fifo.sv]
// short queue between the front end and the parser
module aod_fifo #(
    parameter int WIDTH = 57
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output aod_pkg::fifo_stat_t stat
);
    import aod_pkg::*;

    logic [WIDTH-1:0]      mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   level_reg;
    logic                  do_push;
    logic                  do_pop;

    assign stat.full  = (level_reg == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign stat.empty = (level_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            if (do_push && !do_pop)
                level_reg <= level_reg + (FIFO_PTR_W + 1)'(1);
            else if (do_pop && !do_push)
                level_reg <= level_reg - (FIFO_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/aod_back.sv]
// back end: obu header, extension, leb128 size and payload parser with result register
module aod_back #(
    parameter int LENGTH_BITS = 32,
    parameter int OFFSET_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  aod_pkg::byte_item_t     in_item,
    input  logic [OFFSET_BITS-1:0]  in_offset,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [3:0]              hdr_type,
    output logic                    has_extension,
    output logic                    has_size_field,
    output logic [OFFSET_BITS-1:0]  obu_offset,
    output logic [LENGTH_BITS-1:0]  obu_length,
    output logic [1:0]              status
);
    import aod_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_EXT,
        PH_SIZE,
        PH_PAYLOAD,
        PH_TO_END,
        PH_DROP
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [5:0]             hdr_reg, hdr_next;        // header bits 6..1
    logic [3:0]             shift_cnt_reg, shift_cnt_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [5:0]             out_hdr_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic [LENGTH_BITS-1:0] out_length_reg;
    logic [1:0]             out_status_reg;

    logic                   take;
    logic                   emit;
    logic [1:0]             emit_status;
    logic [6:0]             part;
    logic [6:0]             shift7;
    logic [5:0]             shift;
    logic [63:0]            part_wide;
    logic                   too_big;
    logic [LENGTH_BITS-1:0] size_sum;
    logic [LENGTH_BITS-1:0] count_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign part      = in_item.data[6:0];
    // shift = size bytes taken * 7
    assign shift7    = {shift_cnt_reg, 3'b000} - {3'b000, shift_cnt_reg};
    assign shift     = shift7[5:0];
    assign part_wide = 64'(part) << shift;
    assign too_big   = (part != '0) &&
                       ((shift >= 6'(LENGTH_BITS)) || ((part_wide >> LENGTH_BITS) != '0));
    assign size_sum  = remain_reg | part_wide[LENGTH_BITS-1:0];
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + LENGTH_BITS'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_next       = hdr_reg;
        shift_cnt_next = shift_cnt_reg;
        remain_next    = remain_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        emit           = 1'b0;
        emit_status    = ST_OK;

        if (take)
        begin
            unique case (phase_reg)
                PH_EXT:
                begin
                    count_next = count_inc;
                    if (hdr_reg[0])
                    begin
                        phase_next     = PH_SIZE;
                        shift_cnt_next = '0;
                        remain_next    = '0;
                    end
                    else
                    begin
                        phase_next = PH_TO_END;
                    end
                end
                PH_SIZE:
                begin
                    count_next     = count_inc;
                    shift_cnt_next = shift_cnt_reg + 4'd1;
                    if (too_big)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_TOO_LONG;
                        phase_next  = PH_DROP;
                    end
                    else
                    begin
                        remain_next = size_sum;
                        if (!in_item.data[LEB_CONT_BIT])
                        begin
                            if (size_sum == '0)
                            begin
                                emit       = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        else if (shift_cnt_reg == LEB_LAST_INDEX)
                        begin
                            // ninth size byte still continues
                            emit        = 1'b1;
                            emit_status = ST_TOO_LONG;
                            phase_next  = PH_DROP;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    count_next  = count_inc;
                    remain_next = remain_reg - LENGTH_BITS'(1);
                    if (remain_next == '0)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_TO_END:
                begin
                    count_next = count_inc;
                end
                PH_DROP:
                begin
                end
                default:
                begin
                    hdr_next       = in_item.data[6:1];
                    start_next     = in_offset;
                    count_next     = LENGTH_BITS'(1);
                    shift_cnt_next = '0;
                    remain_next    = '0;
                    if (in_item.data[HDR_FORBIDDEN_BIT])
                    begin
                        emit        = 1'b1;
                        emit_status = ST_FORBIDDEN;
                        phase_next  = PH_DROP;
                    end
                    else if (in_item.data[HDR_EXT_BIT])
                    begin
                        phase_next = PH_EXT;
                    end
                    else if (in_item.data[HDR_SIZE_BIT])
                    begin
                        phase_next = PH_SIZE;
                    end
                    else
                    begin
                        phase_next = PH_TO_END;
                    end
                end
            endcase

            if (in_item.eos)
            begin
                if (!emit)
                begin
                    if (phase_next == PH_TO_END)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_OK;
                    end
                    else if (phase_next == PH_EXT || phase_next == PH_SIZE ||
                             phase_next == PH_PAYLOAD)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_TRUNCATED;
                    end
                end
                phase_next     = PH_IDLE;
                shift_cnt_next = '0;
                remain_next    = '0;
            end
        end

        if (take && emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hdr_reg       <= '0;
            shift_cnt_reg <= '0;
            remain_reg    <= '0;
            start_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_reg       <= hdr_next;
            shift_cnt_reg <= shift_cnt_next;
            remain_reg    <= remain_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_hdr_reg    <= hdr_next;
            out_offset_reg <= start_next;
            out_length_reg <= count_next;
            out_status_reg <= emit_status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hdr_type       = out_hdr_reg[5:2];
    assign has_extension  = out_hdr_reg[1];
    assign has_size_field = out_hdr_reg[0];
    assign obu_offset     = out_offset_reg;
    assign obu_length     = out_length_reg;
    assign status         = out_status_reg;

endmodule

[rtl/av1_obu_stream_deframer.sv]
// top level of the av1 obu stream deframer
//
// input stream: one byte of a low-overhead av1 bitstream per transaction on
// s_tvalid/s_tready, s_tdata[7:0] the byte, s_tlast marking the last byte of
// the stream. output stream: one transaction per finished or failed obu on
// m_tvalid/m_tready with type, flags, start offset and total length in m_tdata
// and the status code in m_tuser (0 complete, 1 forbidden bit, 2 truncated,
// 3 size field too long or overflowing).
// throughput is one byte per cycle while m_tready stays high; a result shows
// on m_tvalid once the byte that ends the obu is taken and has passed the
// front register and the queue into the result register. the parser state
// update in the back end is the loop that sets this rate.
// a 4-entry queue parts the offset-tagging front end from the parser, so when
// the receiver stalls the front end keeps taking bytes until the queue and the
// front register are full, then drops s_tready; no result is lost.
// reset clears the stream offset, the parser state and all valid flags; the
// block is ready for a header byte right after reset. after an error bytes
// are dropped until s_tlast; s_tlast always restarts the offset at zero.
module av1_obu_stream_deframer #(
    parameter int LENGTH_BITS = 32,
    parameter int OFFSET_BITS = 48,
    localparam int OUT_FIELDS_W = 6 + OFFSET_BITS + LENGTH_BITS,
    localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // data_byte
    input  logic             s_tlast,   // last byte of the stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // hdr_type, has_extension, has_size_field, obu_offset, obu_length, zero fill
    output logic [OUT_W-1:0] m_tdata,
    output logic [1:0]       m_tuser    // status
);
    import aod_pkg::*;

    localparam int Q_W = $bits(byte_item_t) + OFFSET_BITS;

    byte_item_t             s_item;
    logic                   fe_valid;
    byte_item_t             fe_item;
    logic [OFFSET_BITS-1:0] fe_offset;
    fifo_stat_t             fifo_stat;
    logic                   fifo_pop;
    logic [Q_W-1:0]         q_out;
    byte_item_t             be_item;
    logic [OFFSET_BITS-1:0] be_offset;
    logic                   be_ready;

    logic [3:0]             hdr_type;
    logic                   has_extension;
    logic                   has_size_field;
    logic [OFFSET_BITS-1:0] obu_offset;
    logic [LENGTH_BITS-1:0] obu_length;

    assign s_item.eos  = s_tlast;
    assign s_item.data = s_tdata;

    aod_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .out_valid  (fe_valid),
        .out_ready  (!fifo_stat.full),
        .out_item   (fe_item),
        .out_offset (fe_offset)
    );

    aod_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_valid),
        .push_data ({fe_offset, fe_item}),
        .pop       (fifo_pop),
        .pop_data  (q_out),
        .stat      (fifo_stat)
    );

    assign be_item   = q_out[$bits(byte_item_t)-1:0];
    assign be_offset = q_out[Q_W-1:$bits(byte_item_t)];
    assign fifo_pop  = !fifo_stat.empty && be_ready;

    aod_back #(
        .LENGTH_BITS (LENGTH_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (!fifo_stat.empty),
        .in_ready       (be_ready),
        .in_item        (be_item),
        .in_offset      (be_offset),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .hdr_type       (hdr_type),
        .has_extension  (has_extension),
        .has_size_field (has_size_field),
        .obu_offset     (obu_offset),
        .obu_length     (obu_length),
        .status         (m_tuser)
    );

    assign m_tdata = OUT_W'({obu_length, obu_offset, has_size_field, has_extension,
                             hdr_type});

    // a stalled result must keep the parser from taking bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !fifo_pop)
        else $error("parser consumed a byte while the result was stalled");

    // a new result can only come from a byte taken out of the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(fifo_pop))
        else $error("result appeared without a parsed byte");

    // a forbidden header ends the obu on its first byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_FORBIDDEN) |-> (obu_length == LENGTH_BITS'(1)))
        else $error("forbidden-bit result with length other than one");

endmodule

[tb/av1_obu_stream_deframer_tb.sv]
// av1 obu stream deframer testbench: directed and random byte streams checked by a predictor
`timescale 1ns / 1ps

module av1_obu_stream_deframer_tb;
    import aod_pkg::*;

    localparam int LEN_W = 32;
    localparam int OFF_W = 48;
    localparam int TDATA_W = ((6 + OFF_W + LEN_W + 7) / 8) * 8;
    localparam int FILL_LO = 6 + OFF_W + LEN_W;
    localparam int STREAM_BYTES = 1550;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 150;
    localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LEN_W);

    typedef enum logic [2:0] {
        P_HEADER,
        P_EXT,
        P_LEB,
        P_BODY,
        P_UNTIL_EOS,
        P_DISCARD
    } parse_step_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    typedef struct packed {
        logic [3:0]       hdr_type;
        logic             has_ext;
        logic             has_size;
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic [1:0]       status;
    } obu_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    byte_item_t stim_q[$];
    obu_rec_t   obu_q[$];
    int         fails = 0;
    int         stall_cycles = 0;

    // predictor state
    parse_step_t      step = P_HEADER;
    logic [7:0]       hdr_byte = '0;
    logic [3:0]       leb_count = '0;
    logic [63:0]      leb_value = '0;
    logic [OFF_W-1:0] stream_off = '0;
    logic [OFF_W-1:0] unit_off = '0;
    logic [LEN_W-1:0] unit_len = '0;

    av1_obu_stream_deframer #(
        .LENGTH_BITS(LEN_W),
        .OFFSET_BITS(OFF_W)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void count_unit_byte();
        if (unit_len != '1)
            unit_len++;
    endfunction

    // advance the parser by one accepted byte, queue the obu it finishes if any
    function automatic void track_byte(input logic [7:0] b, input logic eos);
        logic [63:0] part;
        int          shift;
        logic        done;
        logic [1:0]  st;
        obu_rec_t    rec;
        done = 1'b0;
        st = ST_OK;
        case (step)
            P_EXT:
            begin
                count_unit_byte();
                step = hdr_byte[HDR_SIZE_BIT] ? P_LEB : P_UNTIL_EOS;
                leb_count = '0;
                leb_value = '0;
            end
            P_LEB:
            begin
                part = {57'd0, b[6:0]};
                shift = leb_count * 7;
                count_unit_byte();
                leb_count++;
                if (part != 0 && (shift >= LEN_W || ((part << shift) >> LEN_W) != 0))
                begin
                    done = 1'b1;
                    st = ST_TOO_LONG;
                    step = P_DISCARD;
                end
                else
                begin
                    leb_value |= part << shift;
                    if (!b[LEB_CONT_BIT])
                    begin
                        if (leb_value == 0)
                        begin
                            done = 1'b1;
                            step = P_HEADER;
                        end
                        else
                            step = P_BODY;
                    end
                    else if (leb_count > LEB_LAST_INDEX)
                    begin
                        done = 1'b1;
                        st = ST_TOO_LONG;
                        step = P_DISCARD;
                    end
                end
            end
            P_BODY:
            begin
                count_unit_byte();
                leb_value = (leb_value - 64'd1) & LEN_MASK;
                if (leb_value == 0)
                begin
                    done = 1'b1;
                    step = P_HEADER;
                end
            end
            P_UNTIL_EOS:
                count_unit_byte();
            P_DISCARD:
                ;
            default:
            begin
                hdr_byte = b;
                unit_off = stream_off;
                unit_len = 1;
                leb_count = '0;
                leb_value = '0;
                if (b[HDR_FORBIDDEN_BIT])
                begin
                    done = 1'b1;
                    st = ST_FORBIDDEN;
                    step = P_DISCARD;
                end
                else if (b[HDR_EXT_BIT])
                    step = P_EXT;
                else
                    step = b[HDR_SIZE_BIT] ? P_LEB : P_UNTIL_EOS;
            end
        endcase

        if (eos)
        begin
            if (!done)
            begin
                if (step == P_UNTIL_EOS)
                begin
                    done = 1'b1;
                    st = ST_OK;
                end
                else if (step == P_EXT || step == P_LEB || step == P_BODY)
                begin
                    done = 1'b1;
                    st = ST_TRUNCATED;
                end
            end
            step = P_HEADER;
            leb_count = '0;
            leb_value = '0;
            stream_off = '0;
        end
        else
            stream_off++;

        if (done)
        begin
            rec.hdr_type = hdr_byte[6:3];
            rec.has_ext = hdr_byte[HDR_EXT_BIT];
            rec.has_size = hdr_byte[HDR_SIZE_BIT];
            rec.offset = unit_off;
            rec.length = unit_len;
            rec.status = st;
            obu_q.insert(obu_q.size(), rec);
        end
    endfunction

    task automatic push_byte(input logic [7:0] data, input logic eos);
        byte_item_t item;
        item.eos = eos;
        item.data = data;
        stim_q.insert(stim_q.size(), item);
    endtask

    // one stream: mostly well-formed obus, some with errors, cuts or plain noise
    task automatic add_stream();
        logic [7:0]  sbuf[$];
        logic [7:0]  hdr;
        logic [31:0] size;
        int          mode;
        int          n_units;
        int          k;
        int          nb;
        int          cut;
        bit          failed;
        mode = $urandom_range(0, 99);
        failed = 1'b0;
        if (mode < 8)
        begin
            repeat ($urandom_range(1, 12)) sbuf.insert(sbuf.size(), 8'($urandom));
        end
        else
        begin
            n_units = $urandom_range(1, 5);
            for (int u = 0; u < n_units && !failed; u++)
            begin
                k = $urandom_range(0, 99);
                hdr = {1'b0, 4'($urandom), 1'($urandom), 1'b1, 1'($urandom)};
                if (k >= 80 && k < 87)
                    hdr[HDR_FORBIDDEN_BIT] = 1'b1;
                sbuf.insert(sbuf.size(), hdr);
                if (hdr[HDR_EXT_BIT])
                    sbuf.insert(sbuf.size(), 8'($urandom));
                if (k < 80)
                begin
                    size = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(0, 12);
                    nb = 1;
                    while ((size >> (7 * nb)) != 0)
                        nb++;
                    // redundant continuation bytes now and then
                    if ($urandom_range(0, 4) == 0)
                        nb += $urandom_range(1, 3);
                    if (nb > 9)
                        nb = 9;
                    for (int i = 0; i < nb; i++)
                        sbuf.insert(sbuf.size(), {1'(i < nb - 1), 7'(size >> (7 * i))});
                    repeat (size) sbuf.insert(sbuf.size(), 8'($urandom));
                end
                else if (k < 87)
                    failed = 1'b1;
                else if (k < 93)
                begin
                    for (int i = 0; i < 9; i++)
                        sbuf.insert(sbuf.size(), {1'b1, (i < 4) ? 7'($urandom) : 7'd0});
                    failed = 1'b1;
                end
                else
                begin
                    // size value that does not fit the length counter
                    nb = $urandom_range(4, 8);
                    for (int i = 0; i < nb; i++)
                        sbuf.insert(sbuf.size(),
                                    {1'b1, (i == 4) ? 7'($urandom_range(0, 15))
                                                    : 7'($urandom)});
                    sbuf.insert(sbuf.size(),
                                {1'($urandom), (nb == 4) ? 7'($urandom_range(16, 127))
                                                         : 7'($urandom_range(1, 127))});
                    failed = 1'b1;
                end
            end
            if (failed)
                repeat ($urandom_range(0, 3)) sbuf.insert(sbuf.size(), 8'($urandom));
            else if ($urandom_range(0, 4) == 0)
            begin
                hdr = {1'b0, 4'($urandom), 1'($urandom), 1'b0, 1'($urandom)};
                sbuf.insert(sbuf.size(), hdr);
                if (hdr[HDR_EXT_BIT])
                    sbuf.insert(sbuf.size(), 8'($urandom));
                repeat ($urandom_range(0, 8)) sbuf.insert(sbuf.size(), 8'($urandom));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                cut = $urandom_range(1, sbuf.size());
                while (sbuf.size() > cut)
                    void'(sbuf.pop_back());
            end
        end
        foreach (sbuf[i])
            push_byte(sbuf[i], i == sbuf.size() - 1);
    endtask

    initial
    begin
        // zero payload
        push_byte(8'h12, 1'b0);
        push_byte(8'h00, 1'b0);
        // extension byte and one payload byte
        push_byte(8'h16, 1'b0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFF, 1'b0);
        // forbidden bit, then end while dropping
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        // no size field, type 15, ends at end of stream
        push_byte(8'h79, 1'b0);
        push_byte(8'h55, 1'b1);
        // no size field, end on the header byte
        push_byte(8'h30, 1'b1);
        // end on a header whose extension is still due
        push_byte(8'h34, 1'b1);
        // end inside the size field
        push_byte(8'h0A, 1'b0);
        push_byte(8'h85, 1'b1);
        // nine size bytes all continuing
        push_byte(8'h12, 1'b0);
        repeat (8) push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b1);
        // size value beyond the length counter
        push_byte(8'h12, 1'b0);
        repeat (4) push_byte(8'hFF, 1'b0);
        push_byte(8'h7F, 1'b1);

        while (stim_q.size() < STREAM_BYTES)
            add_stream();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || obu_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // byte driver: bursts of random length with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                track_byte(s_tdata, s_tlast);
                void'(stim_q.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            // a transaction on offer stays until taken
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0 || stim_q.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= stim_q[0].data;
                    s_tlast <= stim_q[0].eos;
                end
            end
        end
    end

    // result receiver: changing stall patterns plus long hold-offs
    rx_mode_t rx_mode;
    int       mode_left;
    int       hold_left;
    int       rx_taken;
    int       next_hold_at;
    int       rx_cycle;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_mode = RX_OPEN;
            mode_left = 0;
            hold_left = 0;
            rx_taken = 0;
            next_hold_at = 20;
            rx_cycle = 0;
        end
        else
        begin
            rx_cycle++;
            if (m_tvalid && m_tready)
                rx_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_taken >= next_hold_at)
            begin
                // long hold-off so the front end fills and drops s_tready
                hold_left = HOLD_CYCLES;
                next_hold_at += 300;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 200);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom);
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_tready <= (rx_cycle % 5 < 2);
                endcase
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    obu_rec_t want_obu;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (obu_q.size() == 0)
            begin
                $error("unexpected result transaction: tdata %0h tuser %0d", m_tdata, m_tuser);
                fails++;
            end
            else
            begin
                want_obu = obu_q.pop_front();
                check_field("hdr_type", 64'(want_obu.hdr_type), 64'(m_tdata[3:0]));
                check_field("has_extension", 64'(want_obu.has_ext), 64'(m_tdata[4]));
                check_field("has_size_field", 64'(want_obu.has_size), 64'(m_tdata[5]));
                check_field("obu_offset", 64'(want_obu.offset), 64'(m_tdata[6 +: OFF_W]));
                check_field("obu_length", 64'(want_obu.length),
                            64'(m_tdata[6 + OFF_W +: LEN_W]));
                check_field("zero fill", 64'd0, 64'(m_tdata[TDATA_W-1:FILL_LO]));
                check_field("status", 64'(want_obu.status), 64'(m_tuser));
            end
        end
    end

    // watchdog: cycles in which neither side moves a transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/aod_pkg.sv
rtl/aod_front.sv
rtl/aod_fifo.sv
rtl/aod_back.sv
rtl/av1_obu_stream_deframer.sv
tb/av1_obu_stream_deframer_tb.sv
